@@ rtl/core/krc_pkg.sv @@
// Shared types, constants and helpers for the keyed result cache.
// Used by every module under rtl/core except krc_ram; depends on nothing.
package krc_pkg;

    localparam int NODES        = 16;
    localparam int WAYS         = 8;
    localparam int NODE_BITS    = 4;
    localparam int WAY_BITS     = 3;
    localparam int SLOT_BITS    = NODE_BITS + WAY_BITS;
    localparam int SLOTS        = NODES * WAYS;
    localparam int FILL_BITS    = 4;
    localparam int SWEEP_BITS   = SLOT_BITS + 1;
    localparam int KEY_BITS     = 64;
    localparam int TIME_BITS    = 32;
    localparam int USE_BITS     = 32;
    localparam int PAYLOAD_BITS = 64;
    localparam int CNT_BITS     = 32;
    localparam int MODE_BITS    = 3;
    localparam int CFG_ADDR_BITS = 2;
    localparam int CFG_DATA_BITS = 32;
    localparam int IN_DATA_BITS  = 168;
    localparam int OUT_DATA_BITS = 160;
    localparam int OUT_USER_BITS = 2;

    // Request modes
    localparam logic [MODE_BITS-1:0] MODE_LOOKUP    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_STORE     = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_INVAL_NODE = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_INVAL_ALL = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_CLEAR     = 3'd4;

    // Configuration register indexes
    localparam logic [CFG_ADDR_BITS-1:0] CFG_ENABLE      = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_TIMEOUT     = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] CFG_MAX_ENTRIES = 2'd2;

    localparam logic [TIME_BITS-1:0] TIMEOUT_RESET = 32'd5000;
    localparam logic [FILL_BITS-1:0] MAX_RESET     = 4'd8;

    // Classified request handed from the front to the back
    typedef struct packed {
        logic [MODE_BITS-1:0]    mode;
        logic                    active;
        logic [NODE_BITS-1:0]    node;
        logic [KEY_BITS-1:0]     key;
        logic [TIME_BITS-1:0]    now;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [FILL_BITS-1:0]    limit;
        logic [TIME_BITS-1:0]    timeout;
    } cmd_t;

    // One cache slot, without its valid bit
    typedef struct packed {
        logic [KEY_BITS-1:0]     key;
        logic [TIME_BITS-1:0]    stamp;
        logic [USE_BITS-1:0]     uses;
        logic [PAYLOAD_BITS-1:0] payload;
    } entry_t;

    localparam int ENTRY_BITS = $bits(entry_t);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_HIT,
        ST_MISS,
        ST_SWEEP,
        ST_RESULT
    } back_state_t;

    // Saturating add of two counter values
    function automatic logic [CNT_BITS-1:0] sat_add(input logic [CNT_BITS-1:0] a,
                                                    input logic [CNT_BITS-1:0] b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_BITS] ? {CNT_BITS{1'b1}} : s[CNT_BITS-1:0];
    endfunction

endpackage

@@ rtl/core/keyed_result_cache_lfu_expiry.sv @@
// Keyed result cache with least-frequently-used replacement and expiry.
// A lookup or store reads the filled ways of its node (0..8) one per cycle, stopping at a live hit;
// invalidate node (for an active node already seen) and invalidate all clear valid bits by a
// one-slot-per-cycle sweep of the valid memory. One request runs at a time, the next starts after a
// result is loaded, and up to two wait in the queue. Reset clears totals, fill counts, seen marks.
module keyed_result_cache_lfu_expiry (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    // node_id[3:0], key_hash[67:4], now_ticks[99:68], payload_in[163:100], zero pad
    input  logic [krc_pkg::IN_DATA_BITS-1:0]      s_tdata,
    // mode[2:0]
    input  logic [krc_pkg::MODE_BITS-1:0]         s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // payload_out[63:0], hit_total[95:64], miss_total[127:96], invalidation_count[159:128]
    output logic [krc_pkg::OUT_DATA_BITS-1:0]     m_tdata,
    // hit_flag[0], evicted_flag[1]
    output logic [krc_pkg::OUT_USER_BITS-1:0]     m_tuser,
    input  logic                                  cfg_we,
    input  logic [krc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [krc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata
);
    import krc_pkg::*;

    logic q_full;
    logic q_push;
    cmd_t q_in;
    logic q_valid;
    logic q_pop;
    cmd_t q_out;

    krc_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_cmd     (q_in)
    );

    krc_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .cmd_in  (q_in),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .cmd_out (q_out)
    );

    krc_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_cmd    (q_out),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

@@ rtl/core/krc_ram.sv @@
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module krc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ rtl/core/krc_front.sv @@
// Front end: configuration registers, input beat acceptance and request classification.
// Depends on krc_pkg.
module krc_front (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [krc_pkg::IN_DATA_BITS-1:0]      s_tdata,
    input  logic [krc_pkg::MODE_BITS-1:0]         s_tuser,
    input  logic                                  cfg_we,
    input  logic [krc_pkg::CFG_ADDR_BITS-1:0]     cfg_addr,
    input  logic [krc_pkg::CFG_DATA_BITS-1:0]     cfg_wdata,
    input  logic                                  q_full,
    output logic                                  q_push,
    output krc_pkg::cmd_t                         q_cmd
);
    import krc_pkg::*;

    logic                 enable_reg;
    logic [TIME_BITS-1:0] timeout_reg;
    logic [FILL_BITS-1:0] max_reg;
    logic [FILL_BITS-1:0] limit;
    logic [NODE_BITS-1:0] node;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg  <= 1'b1;
            timeout_reg <= TIMEOUT_RESET;
            max_reg     <= MAX_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ENABLE:      enable_reg  <= cfg_wdata[0];
                CFG_TIMEOUT:     timeout_reg <= cfg_wdata[TIME_BITS-1:0];
                CFG_MAX_ENTRIES: max_reg     <= cfg_wdata[FILL_BITS-1:0];
                default:         ;
            endcase
        end
    end

    // Entry limit: zero reads as one, capped at the way count
    always_comb
    begin
        if (max_reg == '0)
            limit = FILL_BITS'(1);
        else if (max_reg > FILL_BITS'(WAYS))
            limit = FILL_BITS'(WAYS);
        else
            limit = max_reg;
    end

    assign node     = s_tdata[NODE_BITS-1:0];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && s_tready;

    // Unpack the beat and classify it
    always_comb
    begin
        q_cmd.mode    = s_tuser;
        q_cmd.node    = node;
        q_cmd.active  = enable_reg && ({1'b0, node} < (NODE_BITS+1)'(NODES));
        q_cmd.key     = s_tdata[NODE_BITS +: KEY_BITS];
        q_cmd.now     = s_tdata[NODE_BITS+KEY_BITS +: TIME_BITS];
        q_cmd.payload = s_tdata[NODE_BITS+KEY_BITS+TIME_BITS +: PAYLOAD_BITS];
        q_cmd.limit   = limit;
        q_cmd.timeout = timeout_reg;
    end

endmodule

@@ rtl/core/krc_queue.sv @@
// Two-entry request queue between the front and back ends.
// Depends on krc_pkg.
module krc_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  krc_pkg::cmd_t cmd_in,
    output logic          full,
    input  logic          pop,
    output logic          valid,
    output krc_pkg::cmd_t cmd_out
);
    import krc_pkg::*;

    cmd_t       slot_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;

    assign full    = (count_reg == 2'd2);
    assign valid   = (count_reg != 2'd0);
    assign cmd_out = slot_reg[rd_ptr_reg];

    // Pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= !rd_ptr_reg;
            count_reg <= count_reg + 2'(push) - 2'(pop);
        end
    end

    // Payload storage
    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= cmd_in;
    end

endmodule

@@ rtl/core/krc_back.sv @@
// Back end: executes requests against the slot memories, keeps totals, drives results.
// Depends on krc_pkg and krc_ram.
module krc_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_valid,
    input  krc_pkg::cmd_t                        q_cmd,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [krc_pkg::OUT_DATA_BITS-1:0]    m_tdata,
    output logic [krc_pkg::OUT_USER_BITS-1:0]    m_tuser
);
    import krc_pkg::*;

    back_state_t state_reg, state_next;
    cmd_t        cmd_reg, cmd_next;

    logic [FILL_BITS-1:0]  rd_idx_reg, rd_idx_next;
    logic                  chk_v_reg, chk_v_next;
    logic [WAY_BITS-1:0]   chk_idx_reg, chk_idx_next;
    logic [FILL_BITS-1:0]  n_reg, n_next;
    logic                  best_v_reg, best_v_next;
    logic [WAY_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [USE_BITS-1:0]   best_uses_reg, best_uses_next;
    logic [WAY_BITS-1:0]   hit_idx_reg, hit_idx_next;
    entry_t                ent_reg, ent_next;
    logic [SWEEP_BITS-1:0] sweep_reg, sweep_next;
    logic [SWEEP_BITS-1:0] sweep_end_reg, sweep_end_next;

    logic [FILL_BITS-1:0]  fill_reg [NODES];
    logic [FILL_BITS-1:0]  fill_next [NODES];
    logic [NODES-1:0]      seen_reg, seen_next;
    logic [CNT_BITS-1:0]   hit_tot_reg, hit_tot_next;
    logic [CNT_BITS-1:0]   miss_tot_reg, miss_tot_next;
    logic [CNT_BITS-1:0]   inv_tot_reg, inv_tot_next;

    logic                    res_hit_reg, res_hit_next;
    logic                    res_evict_reg, res_evict_next;
    logic [PAYLOAD_BITS-1:0] res_pay_reg, res_pay_next;

    logic                    out_valid_reg;
    logic                    out_hit_reg;
    logic                    out_evict_reg;
    logic [PAYLOAD_BITS-1:0] out_pay_reg;
    logic [CNT_BITS-1:0]     out_hits_reg;
    logic [CNT_BITS-1:0]     out_miss_reg;
    logic [CNT_BITS-1:0]     out_inv_reg;
    logic                    out_load;

    // RAM ports
    logic                 ent_we;
    logic [SLOT_BITS-1:0] ent_waddr;
    entry_t               ent_wdata;
    logic [SLOT_BITS-1:0] raddr;
    entry_t               ent_rdata;
    logic                 vld_we;
    logic [SLOT_BITS-1:0] vld_waddr;
    logic                 vld_wdata;
    logic                 vld_rdata;

    // Scan checks on the data that just came back
    logic                 key_match;
    logic [TIME_BITS-1:0] age;
    logic                 expired;
    logic                 scan_done;

    krc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(SLOTS)) u_entry_ram (
        .clk   (clk),
        .we    (ent_we),
        .waddr (ent_waddr),
        .wdata (ent_wdata),
        .raddr (raddr),
        .rdata (ent_rdata)
    );

    krc_ram #(.WIDTH(1), .DEPTH(SLOTS)) u_valid_ram (
        .clk   (clk),
        .we    (vld_we),
        .waddr (vld_waddr),
        .wdata (vld_wdata),
        .raddr (raddr),
        .rdata (vld_rdata)
    );

    assign key_match = chk_v_reg && vld_rdata && (ent_rdata.key == cmd_reg.key);
    assign age       = cmd_reg.now - ent_rdata.stamp;
    assign expired   = (cmd_reg.timeout != '0) && (age > cmd_reg.timeout);
    assign scan_done = !chk_v_reg && (rd_idx_reg >= n_reg);
    assign out_load  = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    case (q_cmd.mode) inside
                        MODE_LOOKUP, MODE_STORE:
                            state_next = q_cmd.active ? ST_SCAN : ST_RESULT;
                        MODE_INVAL_NODE:
                            state_next = (q_cmd.active && seen_reg[q_cmd.node]) ?
                                         ST_SWEEP : ST_RESULT;
                        MODE_INVAL_ALL:
                            state_next = ST_SWEEP;
                        default:
                            state_next = ST_RESULT;
                    endcase
                end
            end
            ST_SCAN:
            begin
                if (key_match && !expired)
                    state_next = ST_HIT;
                else if (scan_done)
                    state_next = ST_MISS;
            end
            ST_HIT:    state_next = ST_RESULT;
            ST_MISS:   state_next = ST_RESULT;
            ST_SWEEP:
            begin
                if (sweep_reg + SWEEP_BITS'(1) == sweep_end_reg)
                    state_next = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // Datapath and memory controls
    always_comb
    begin
        cmd_next       = cmd_reg;
        rd_idx_next    = rd_idx_reg;
        chk_v_next     = 1'b0;
        chk_idx_next   = chk_idx_reg;
        n_next         = n_reg;
        best_v_next    = best_v_reg;
        best_idx_next  = best_idx_reg;
        best_uses_next = best_uses_reg;
        hit_idx_next   = hit_idx_reg;
        ent_next       = ent_reg;
        sweep_next     = sweep_reg;
        sweep_end_next = sweep_end_reg;
        fill_next      = fill_reg;
        seen_next      = seen_reg;
        hit_tot_next   = hit_tot_reg;
        miss_tot_next  = miss_tot_reg;
        inv_tot_next   = inv_tot_reg;
        res_hit_next   = res_hit_reg;
        res_evict_next = res_evict_reg;
        res_pay_next   = res_pay_reg;
        q_pop          = 1'b0;
        ent_we         = 1'b0;
        ent_waddr      = {cmd_reg.node, hit_idx_reg};
        ent_wdata      = ent_reg;
        raddr          = {cmd_reg.node, rd_idx_reg[WAY_BITS-1:0]};
        vld_we         = 1'b0;
        vld_waddr      = {cmd_reg.node, chk_idx_reg};
        vld_wdata      = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop          = 1'b1;
                    cmd_next       = q_cmd;
                    rd_idx_next    = '0;
                    best_v_next    = 1'b0;
                    n_next         = fill_reg[q_cmd.node];
                    res_hit_next   = 1'b0;
                    res_evict_next = 1'b0;
                    res_pay_next   = '0;
                    case (q_cmd.mode) inside
                        MODE_LOOKUP, MODE_STORE:
                        begin
                            if (q_cmd.active)
                                seen_next[q_cmd.node] = 1'b1;
                        end
                        MODE_INVAL_NODE:
                        begin
                            if (q_cmd.active && seen_reg[q_cmd.node])
                            begin
                                inv_tot_next   = sat_add(inv_tot_reg, CNT_BITS'(1));
                                sweep_next     = {1'b0, q_cmd.node, {WAY_BITS{1'b0}}};
                                sweep_end_next = {1'b0, q_cmd.node, {WAY_BITS{1'b0}}} +
                                                 SWEEP_BITS'(WAYS);
                            end
                        end
                        MODE_INVAL_ALL:
                        begin
                            inv_tot_next   = sat_add(inv_tot_reg,
                                                     CNT_BITS'($countones(seen_reg)));
                            sweep_next     = '0;
                            sweep_end_next = SWEEP_BITS'(SLOTS);
                        end
                        MODE_CLEAR:
                        begin
                            for (int j = 0; j < NODES; j++)
                                fill_next[j] = '0;
                            hit_tot_next  = '0;
                            miss_tot_next = '0;
                            inv_tot_next  = '0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SCAN:
            begin
                // Issue the next read while checking the previous one
                if (rd_idx_reg < n_reg)
                begin
                    rd_idx_next  = rd_idx_reg + FILL_BITS'(1);
                    chk_v_next   = 1'b1;
                    chk_idx_next = rd_idx_reg[WAY_BITS-1:0];
                end
                if (chk_v_reg)
                begin
                    if (!best_v_reg || ent_rdata.uses < best_uses_reg)
                    begin
                        best_v_next    = 1'b1;
                        best_idx_next  = chk_idx_reg;
                        best_uses_next = ent_rdata.uses;
                    end
                    if (key_match && expired)
                    begin
                        vld_we    = 1'b1;
                        vld_wdata = 1'b0;
                    end
                    else if (key_match)
                    begin
                        hit_idx_next = chk_idx_reg;
                        ent_next     = ent_rdata;
                    end
                end
            end
            ST_HIT:
            begin
                // Bump the use count; a store also refreshes payload and stamp
                ent_we    = 1'b1;
                ent_wdata = ent_reg;
                if (ent_reg.uses != {USE_BITS{1'b1}})
                    ent_wdata.uses = ent_reg.uses + USE_BITS'(1);
                if (cmd_reg.mode == MODE_STORE)
                begin
                    ent_wdata.payload = cmd_reg.payload;
                    ent_wdata.stamp   = cmd_reg.now;
                end
                else
                begin
                    res_hit_next = 1'b1;
                    res_pay_next = ent_reg.payload;
                    hit_tot_next = sat_add(hit_tot_reg, CNT_BITS'(1));
                end
            end
            ST_MISS:
            begin
                if (cmd_reg.mode == MODE_STORE)
                begin
                    ent_we            = 1'b1;
                    vld_we            = 1'b1;
                    vld_wdata         = 1'b1;
                    ent_wdata.key     = cmd_reg.key;
                    ent_wdata.stamp   = cmd_reg.now;
                    ent_wdata.uses    = '0;
                    ent_wdata.payload = cmd_reg.payload;
                    if (n_reg >= cmd_reg.limit)
                    begin
                        ent_waddr      = {cmd_reg.node, best_idx_reg};
                        res_evict_next = 1'b1;
                    end
                    else
                    begin
                        ent_waddr                = {cmd_reg.node, n_reg[WAY_BITS-1:0]};
                        fill_next[cmd_reg.node]  = n_reg + FILL_BITS'(1);
                    end
                    vld_waddr = ent_waddr;
                end
                else
                begin
                    miss_tot_next = sat_add(miss_tot_reg, CNT_BITS'(1));
                end
            end
            ST_SWEEP:
            begin
                vld_we     = 1'b1;
                vld_wdata  = 1'b0;
                vld_waddr  = sweep_reg[SLOT_BITS-1:0];
                sweep_next = sweep_reg + SWEEP_BITS'(1);
            end
            ST_RESULT: ;
            default: ;
        endcase
    end

    // Control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            chk_v_reg    <= 1'b0;
            seen_reg     <= '0;
            hit_tot_reg  <= '0;
            miss_tot_reg <= '0;
            inv_tot_reg  <= '0;
            out_valid_reg <= 1'b0;
            for (int j = 0; j < NODES; j++)
                fill_reg[j] <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            chk_v_reg    <= chk_v_next;
            seen_reg     <= seen_next;
            hit_tot_reg  <= hit_tot_next;
            miss_tot_reg <= miss_tot_next;
            inv_tot_reg  <= inv_tot_next;
            fill_reg     <= fill_next;
            if (state_reg == ST_RESULT && out_load)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        rd_idx_reg    <= rd_idx_next;
        chk_idx_reg   <= chk_idx_next;
        n_reg         <= n_next;
        best_v_reg    <= best_v_next;
        best_idx_reg  <= best_idx_next;
        best_uses_reg <= best_uses_next;
        hit_idx_reg   <= hit_idx_next;
        ent_reg       <= ent_next;
        sweep_reg     <= sweep_next;
        sweep_end_reg <= sweep_end_next;
        res_hit_reg   <= res_hit_next;
        res_evict_reg <= res_evict_next;
        res_pay_reg   <= res_pay_next;
        if (state_reg == ST_RESULT && out_load)
        begin
            out_hit_reg   <= res_hit_reg;
            out_evict_reg <= res_evict_reg;
            out_pay_reg   <= res_pay_reg;
            out_hits_reg  <= hit_tot_reg;
            out_miss_reg  <= miss_tot_reg;
            out_inv_reg   <= inv_tot_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_inv_reg, out_miss_reg, out_hits_reg, out_pay_reg};
    assign m_tuser  = {out_evict_reg, out_hit_reg};

endmodule

@@ test/testbench.sv @@
// Self-checking testbench for the keyed result cache with LFU replacement and expiry.
// Depends on krc_pkg and keyed_result_cache_lfu_expiry; reads no files and needs no arguments.
module testbench;
    import krc_pkg::*;

    localparam int LIMIT_CYCLES = 2000000;
    localparam int DRAIN_CYCLES = 200;
    localparam int PHASES       = 6;

    typedef struct {
        logic [MODE_BITS-1:0]    mode;
        logic [NODE_BITS-1:0]    node;
        logic [KEY_BITS-1:0]     key;
        logic [TIME_BITS-1:0]    now;
        logic [PAYLOAD_BITS-1:0] pay;
        bit                      typed;
        bit                      t_hit;
        logic [PAYLOAD_BITS-1:0] t_pay;
        bit                      t_evict;
    } req_t;

    typedef struct {
        bit                      hit;
        logic [PAYLOAD_BITS-1:0] pay;
        bit                      evict;
        logic [CNT_BITS-1:0]     hits;
        logic [CNT_BITS-1:0]     misses;
        logic [CNT_BITS-1:0]     invals;
    } reply_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [IN_DATA_BITS-1:0]  s_tdata;
    logic [MODE_BITS-1:0]     s_tuser;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [OUT_DATA_BITS-1:0] m_tdata;
    logic [OUT_USER_BITS-1:0] m_tuser;
    logic                     cfg_we;
    logic [CFG_ADDR_BITS-1:0] cfg_addr;
    logic [CFG_DATA_BITS-1:0] cfg_wdata;

    // Shadow copy of the cache contents and configuration
    bit                      sh_valid [SLOTS];
    logic [KEY_BITS-1:0]     sh_key   [SLOTS];
    logic [TIME_BITS-1:0]    sh_stamp [SLOTS];
    logic [USE_BITS-1:0]     sh_uses  [SLOTS];
    logic [PAYLOAD_BITS-1:0] sh_pay   [SLOTS];
    int unsigned             sh_fill  [NODES];
    bit                      sh_seen  [NODES];
    logic [CNT_BITS-1:0]     sh_hits, sh_misses, sh_invals;
    bit                      sh_enable;
    logic [TIME_BITS-1:0]    sh_timeout;
    logic [FILL_BITS-1:0]    sh_max;

    reply_t                  pending_replies [$];
    int                      errors;
    int unsigned             cycle_count;
    int                      tx_idle_pct;
    int                      rx_idle_pct;
    logic [KEY_BITS-1:0]     key_pool [12];
    logic [TIME_BITS-1:0]    cur_now;

    keyed_result_cache_lfu_expiry dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #2 clk = ~clk;

    function automatic logic [CNT_BITS-1:0] bump(logic [CNT_BITS-1:0] a, int unsigned b);
        logic [CNT_BITS:0] s;
        s = {1'b0, a} + b;
        return s[CNT_BITS] ? '1 : s[CNT_BITS-1:0];
    endfunction

    // Scan a node for a live matching entry; expired matches are dropped on the way.
    function automatic int find_live(int node, logic [KEY_BITS-1:0] key,
                                     logic [TIME_BITS-1:0] now);
        int base;
        int n;
        logic [TIME_BITS-1:0] age;
        base = node * WAYS;
        n = (sh_fill[node] > WAYS) ? WAYS : sh_fill[node];
        for (int i = 0; i < n; i++) begin
            if (sh_valid[base+i] && sh_key[base+i] == key) begin
                age = now - sh_stamp[base+i];
                if (sh_timeout != 0 && age > sh_timeout) begin
                    sh_valid[base+i] = 0;
                    continue;
                end
                if (sh_uses[base+i] != '1)
                    sh_uses[base+i]++;
                return base + i;
            end
        end
        return -1;
    endfunction

    function automatic reply_t predict_cache(req_t r);
        reply_t o;
        int s;
        int n;
        int lim;
        int best;
        int base;
        int seen;
        o = '{default: 0};
        base = r.node * WAYS;
        case (r.mode)
            MODE_LOOKUP: if (sh_enable)
            begin
                sh_seen[r.node] = 1;
                s = find_live(r.node, r.key, r.now);
                if (s >= 0)
                begin
                    o.hit = 1;
                    o.pay = sh_pay[s];
                    sh_hits = bump(sh_hits, 1);
                end
                else
                    sh_misses = bump(sh_misses, 1);
            end
            MODE_STORE: if (sh_enable)
            begin
                sh_seen[r.node] = 1;
                s = find_live(r.node, r.key, r.now);
                if (s < 0)
                begin
                    lim = (sh_max == 0) ? 1 : sh_max;
                    if (lim > WAYS) lim = WAYS;
                    n = (sh_fill[r.node] > WAYS) ? WAYS : sh_fill[r.node];
                    if (n >= lim)
                    begin
                        best = 0;
                        for (int i = 1; i < n; i++)
                            if (sh_uses[base+i] < sh_uses[base+best]) best = i;
                        s = base + best;
                        o.evict = 1;
                    end
                    else
                    begin
                        s = base + n;
                        sh_fill[r.node] = n + 1;
                    end
                    sh_key[s] = r.key;
                    sh_uses[s] = 0;
                end
                sh_pay[s] = r.pay;
                sh_stamp[s] = r.now;
                sh_valid[s] = 1;
            end
            MODE_INVAL_NODE: if (sh_enable && sh_seen[r.node])
            begin
                for (int i = 0; i < WAYS; i++) sh_valid[base+i] = 0;
                sh_invals = bump(sh_invals, 1);
            end
            MODE_INVAL_ALL:
            begin
                seen = 0;
                for (int j = 0; j < NODES; j++)
                begin
                    for (int i = 0; i < WAYS; i++) sh_valid[j*WAYS+i] = 0;
                    if (sh_seen[j]) seen++;
                end
                sh_invals = bump(sh_invals, seen);
            end
            MODE_CLEAR:
            begin
                foreach (sh_fill[j]) sh_fill[j] = 0;
                sh_hits = 0;
                sh_misses = 0;
                sh_invals = 0;
            end
            default: ;
        endcase
        o.hits = sh_hits;
        o.misses = sh_misses;
        o.invals = sh_invals;
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch in %s at cycle %0d: got %h, expected %h", what, cycle_count, got, want);
        errors++;
    endtask

    // Compare every accepted result beat against the oldest expected reply
    always @(posedge clk)
    begin
        reply_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_replies.size() == 0)
            begin
                report_mismatch("unexpected result beat", m_tdata[63:0], 64'd0);
            end
            else
            begin
                e = pending_replies.pop_front();
                if (m_tuser[0] !== e.hit) report_mismatch("hit_flag", m_tuser[0], e.hit);
                if (m_tuser[1] !== e.evict) report_mismatch("evicted_flag", m_tuser[1], e.evict);
                if (m_tdata[63:0] !== e.pay) report_mismatch("payload_out", m_tdata[63:0], e.pay);
                if (m_tdata[95:64] !== e.hits)
                    report_mismatch("hit total", m_tdata[95:64], e.hits);
                if (m_tdata[127:96] !== e.misses)
                    report_mismatch("miss total", m_tdata[127:96], e.misses);
                if (m_tdata[159:128] !== e.invals)
                    report_mismatch("invalidation_count", m_tdata[159:128], e.invals);
            end
        end
    end

    // Receiver stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= rx_idle_pct);

    // Run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_request(req_t r);
        reply_t e;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 0;
            @(posedge clk);
        end
        s_tvalid <= 1;
        s_tuser  <= r.mode;
        s_tdata  <= {4'b0, r.pay, r.now, r.key, r.node};
        do @(posedge clk); while (!s_tready);
        e = predict_cache(r);
        if (r.typed && (e.hit != r.t_hit || e.pay != r.t_pay || e.evict != r.t_evict))
            report_mismatch("typed expectation", {e.evict, e.hit}, {r.t_evict, r.t_hit});
        pending_replies.push_back(e);
    endtask

    // Drain all results, then allow the longest sweep to finish
    task automatic wait_idle();
        s_tvalid <= 0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_ADDR_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
        cfg_we    <= 1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        case (idx)
            CFG_ENABLE:      sh_enable  = val[0];
            CFG_TIMEOUT:     sh_timeout = val;
            CFG_MAX_ENTRIES: sh_max     = val[FILL_BITS-1:0];
            default: ;
        endcase
    endtask

    function automatic req_t row(logic [MODE_BITS-1:0] m, logic [NODE_BITS-1:0] node,
                                 logic [63:0] key, logic [31:0] now, logic [63:0] pay,
                                 bit typed = 0, bit hit = 0, logic [63:0] tpay = 0,
                                 bit ev = 0);
        req_t r;
        r = '{m, node, key, now, pay, typed, hit, tpay, ev};
        return r;
    endfunction

    function automatic req_t random_request();
        req_t r;
        int pick;
        pick = $urandom_range(99);
        if (pick < 45) r.mode = MODE_LOOKUP;
        else if (pick < 85) r.mode = MODE_STORE;
        else if (pick < 92) r.mode = MODE_INVAL_NODE;
        else if (pick < 94) r.mode = MODE_INVAL_ALL;
        else if (pick < 96) r.mode = MODE_CLEAR;
        else r.mode = 3'($urandom_range(7, 5));
        // Most nodes come from a small group so entries pile up and get evicted
        r.node = ($urandom_range(3) == 0) ? 4'($urandom_range(15)) : 4'($urandom_range(3));
        r.key = ($urandom_range(9) == 0) ? {$urandom, $urandom} : key_pool[$urandom_range(11)];
        pick = $urandom_range(99);
        if (pick < 3) cur_now = $urandom;
        else if (pick < 8) cur_now += $urandom_range(20000);
        else cur_now += $urandom_range(800);
        r.now = cur_now;
        r.pay = {$urandom, $urandom};
        r.typed = 0;
        return r;
    endfunction

    initial
    begin
        req_t directed [$];
        bit          ph_en  [PHASES] = '{1, 1, 1, 0, 1, 1};
        logic [31:0] ph_to  [PHASES] = '{5000, 0, 32'hFFFF_FFFF, 2000, 5000, 1};
        logic [3:0]  ph_max [PHASES] = '{8, 1, 0, 15, 3, 8};
        int          ph_cnt [PHASES] = '{100, 110, 110, 40, 130, 110};
        int          ph_tx  [PHASES] = '{18, 18, 58, 58, 0, 0};
        int          ph_rx  [PHASES] = '{58, 58, 18, 18, 0, 0};

        clk = 0;
        rst_n = 0;
        s_tvalid = 0;
        s_tdata = '0;
        s_tuser = MODE_LOOKUP;
        m_tready = 0;
        cfg_we = 0;
        cfg_addr = CFG_ENABLE;
        cfg_wdata = '0;
        errors = 0;
        cycle_count = 0;
        tx_idle_pct = 18;
        rx_idle_pct = 58;
        cur_now = 0;
        foreach (key_pool[i]) key_pool[i] = {$urandom, $urandom};
        foreach (sh_fill[j])
        begin
            sh_fill[j] = 0;
            sh_seen[j] = 0;
        end
        sh_hits = 0;
        sh_misses = 0;
        sh_invals = 0;
        sh_enable = 1;
        sh_timeout = TIMEOUT_RESET;
        sh_max = MAX_RESET;

        repeat (3) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed part under the reset configuration
        directed.push_back(row(MODE_LOOKUP, 0, 0, 0, 0, 1, 0, 0, 0));
        directed.push_back(row(MODE_STORE, 0, 0, 0, '1, 1, 0, 0, 0));
        // Age exactly at the timeout still hits, one tick beyond expires
        directed.push_back(row(MODE_LOOKUP, 0, 0, 5000, 0, 1, 1, '1, 0));
        directed.push_back(row(MODE_LOOKUP, 0, 0, 5001, 0, 1, 0, 0, 0));
        // Age computed across the time wrap
        directed.push_back(row(MODE_STORE, 15, '1, '1, 0, 1, 0, 0, 0));
        directed.push_back(row(MODE_LOOKUP, 15, '1, 4999, '1, 1, 1, 0, 0));
        directed.push_back(row(MODE_STORE, 15, '1, 5000, 64'hA5A5, 1, 0, 0, 0));
        directed.push_back(row(MODE_INVAL_NODE, 15, 0, 5000, 0));
        directed.push_back(row(MODE_LOOKUP, 15, '1, 5000, 0, 1, 0, 0, 0));
        // Invalidating a node never looked at does not count
        directed.push_back(row(MODE_INVAL_NODE, 7, 0, 5000, 0));
        // Fill node 2 beyond its eight ways; the last store evicts
        for (int i = 1; i <= 9; i++)
            directed.push_back(row(MODE_STORE, 2, 64'(i), 6000, 64'(i), 1, 0, 0, i == 9));
        directed.push_back(row(MODE_INVAL_ALL, 0, 0, 6000, 0));
        directed.push_back(row(MODE_CLEAR, 0, 0, 6000, 0));
        directed.push_back(row(3'd5, 3, '1, '1, '1, 1, 0, 0, 0));
        directed.push_back(row(3'd7, 8, 0, 0, 0, 1, 0, 0, 0));
        foreach (directed[i]) send_request(directed[i]);
        cur_now = 6000;

        // Random phases, each under its own configuration
        for (int p = 0; p < PHASES; p++)
        begin
            wait_idle();
            write_reg(CFG_ENABLE, CFG_DATA_BITS'(ph_en[p]));
            write_reg(CFG_TIMEOUT, ph_to[p]);
            write_reg(CFG_MAX_ENTRIES, CFG_DATA_BITS'(ph_max[p]));
            cfg_we <= 0;
            tx_idle_pct = ph_tx[p];
            rx_idle_pct = ph_rx[p];
            for (int i = 0; i < ph_cnt[p]; i++) send_request(random_request());
        end
        wait_idle();

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

@@ keyed_result_cache_lfu_expiry.f @@
rtl/core/krc_pkg.sv
rtl/core/krc_ram.sv
rtl/core/krc_front.sv
rtl/core/krc_queue.sv
rtl/core/krc_back.sv
rtl/core/keyed_result_cache_lfu_expiry.sv
test/testbench.sv
